/* rtl/rrel_pkg.sv */
`timescale 1ns / 1ps

package rrel_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 13;
	localparam int MIN_DIM    = 3;

	// Pixel and result widths
	localparam int PIX_W      = 8;
	localparam int FRAC_W     = 8;
	localparam int END_W      = 20;
	localparam int SUM_W      = 36;
	localparam int CNT_W      = 25;
	// upper part of (sum << FRAC_W) that seeds the divider remainder
	localparam int NUM_HI_W   = SUM_W + FRAC_W - END_W;
	localparam int STEP_W     = $clog2(END_W);

	// Edge kinds
	localparam int KINDS      = 4;
	localparam int KIND_W     = $clog2(KINDS);
	localparam logic [KIND_W-1:0] KIND_LEFT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RIGHT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TOP    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd3;

	// Configuration
	localparam int CFG_IDX_W  = 3;
	localparam logic [PIX_W-1:0] RED_THR_RST   = 8'd120;
	localparam logic [PIX_W-1:0] GREEN_THR_RST = 8'd90;
	localparam logic [PIX_W-1:0] BLUE_THR_RST  = 8'd90;
	localparam logic [DIM_W-1:0] WIDTH_RST     = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd480;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_THR,
		REG_GREEN_THR,
		REG_BLUE_THR,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_blue;
		logic [PIX_W-1:0] pixel_green;
		logic [PIX_W-1:0] pixel_red;
	} pixel_item_t;

	typedef struct packed {
		logic             pixel_is_red;
		logic             frame_done;
		logic [END_W-1:0] left_end;
		logic [END_W-1:0] right_end;
		logic [END_W-1:0] top_end;
		logic [END_W-1:0] bottom_end;
		logic [KINDS-1:0] empty_mask;
	} result_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_thr;
		logic [PIX_W-1:0] green_thr;
		logic [PIX_W-1:0] blue_thr;
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
	} cfg_regs_t;

	// Totals of one frame, handed to the divider on the last pixel
	typedef struct packed {
		logic                        pixel_is_red;
		logic [KINDS-1:0][SUM_W-1:0] pos_sum;
		logic [KINDS-1:0][CNT_W-1:0] count;
	} frame_stats_t;

endpackage

/* rtl/rrel_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module rrel_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/rrel_accum.sv */
`timescale 1ns / 1ps

// Pixel path: colour test, raster position, row store and edge totals
module rrel_accum
	import rrel_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_regs_t    cfg,
	input  logic         accept,
	input  pixel_item_t  pix,
	output logic         is_red,
	output logic         frame_end,
	output frame_stats_t stats
);

	logic [COL_W-1:0]            col_q, col_nx;
	logic [ROW_W-1:0]            row_q;
	logic                        prev_pix_q;
	logic [KINDS-1:0][SUM_W-1:0] sums_q, sums_nx, pos_add;
	logic [KINDS-1:0][CNT_W-1:0] cnt_q, cnt_nx;
	logic [KINDS-1:0]            ev;
	logic [DIM_W-1:0]            width_c, height_c;
	logic [DIM_W-1:0]            col_ext, row_ext;
	logic                        row_end;
	logic                        above;

	// Clamp geometry into its legal range
	always_comb begin
		width_c = cfg.frame_width;
		if (cfg.frame_width < DIM_W'(MIN_DIM)) begin
			width_c = DIM_W'(MIN_DIM);
		end else if (cfg.frame_width > DIM_W'(MAX_WIDTH)) begin
			width_c = DIM_W'(MAX_WIDTH);
		end
		height_c = cfg.frame_height;
		if (cfg.frame_height < DIM_W'(MIN_DIM)) begin
			height_c = DIM_W'(MIN_DIM);
		end else if (cfg.frame_height > DIM_W'(MAX_HEIGHT)) begin
			height_c = DIM_W'(MAX_HEIGHT);
		end
	end

	assign col_ext   = DIM_W'(col_q);
	assign row_ext   = DIM_W'(row_q);
	assign row_end   = col_ext >= width_c - DIM_W'(1);
	assign frame_end = row_end && (row_ext >= height_c - DIM_W'(1));

	assign is_red = (pix.pixel_red > cfg.red_thr) && (pix.pixel_blue < cfg.blue_thr)
		&& (pix.pixel_green < cfg.green_thr);

	// Edge events of this pixel, border rows and columns excluded
	always_comb begin
		ev[KIND_LEFT]   = (col_q != '0) && (col_ext <= width_c - DIM_W'(2))
			&& is_red && !prev_pix_q;
		ev[KIND_RIGHT]  = (col_q >= COL_W'(2)) && (col_ext <= width_c - DIM_W'(1))
			&& prev_pix_q && !is_red;
		ev[KIND_TOP]    = (row_q != '0) && (row_ext <= height_c - DIM_W'(2))
			&& is_red && !above;
		ev[KIND_BOTTOM] = (row_q >= ROW_W'(2)) && (row_ext <= height_c - DIM_W'(1))
			&& above && !is_red;
		pos_add[KIND_LEFT]   = SUM_W'(col_q);
		pos_add[KIND_RIGHT]  = SUM_W'(col_q - COL_W'(1));
		pos_add[KIND_TOP]    = SUM_W'(row_q);
		pos_add[KIND_BOTTOM] = SUM_W'(row_q - ROW_W'(1));
		for (int k = 0; k < KINDS; k++) begin
			sums_nx[k] = sums_q[k] + (ev[k] ? pos_add[k] : '0);
			cnt_nx[k]  = cnt_q[k] + CNT_W'(ev[k]);
		end
	end

	assign stats.pixel_is_red = is_red;
	assign stats.pos_sum      = sums_nx;
	assign stats.count        = cnt_nx;

	// Next column; also the row store read address, so the upper
	// neighbour is ready when the next item arrives
	always_comb begin
		col_nx = col_q;
		if (accept) begin
			col_nx = row_end ? '0 : col_q + COL_W'(1);
		end
	end

	rrel_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(is_red),
		.rd_addr(col_nx),
		.rd_data(above)
	);

	// Position and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			prev_pix_q <= 1'b0;
			sums_q     <= '0;
			cnt_q      <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			if (frame_end) begin
				row_q      <= '0;
				prev_pix_q <= 1'b0;
				sums_q     <= '0;
				cnt_q      <= '0;
			end else begin
				prev_pix_q <= is_red;
				sums_q     <= sums_nx;
				cnt_q      <= cnt_nx;
				if (row_end) begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

	// Row store never reads the entry being written
	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> col_nx != col_q)
		else $error("row store read and write hit the same column");

endmodule

/* rtl/rrel_div.sv */
`timescale 1ns / 1ps

// Shared restoring divider: four means, one quotient bit a cycle
module rrel_div
	import rrel_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  frame_stats_t stats,
	input  logic         taken,
	output logic         busy,
	output logic         res_valid,
	output result_item_t res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_HOLD
	} state_t;

	state_t                      state_q;
	frame_stats_t                stats_q;
	logic [KIND_W-1:0]           kind_q;
	logic [STEP_W-1:0]           step_q;
	logic [CNT_W-1:0]            rem_q;
	logic [END_W-1:0]            num_q;
	logic [END_W-1:0]            quo_q;
	logic [KINDS-1:0][END_W-1:0] ends_q;
	logic [KINDS-1:0]            empty_q;

	logic [SUM_W-1:0]    sum_sel;
	logic [CNT_W-1:0]    cnt_sel;
	logic [NUM_HI_W-1:0] num_hi;
	logic [END_W-1:0]    num_lo;
	logic                too_big;
	logic [CNT_W:0]      trial, diff;
	logic                ge;
	logic [END_W-1:0]    quo_nx;
	logic                last_kind;

	// Operands of the current kind; numerator is sum << FRAC_W
	assign sum_sel = stats_q.pos_sum[kind_q];
	assign cnt_sel = stats_q.count[kind_q];
	assign num_hi  = sum_sel[SUM_W-1 -: NUM_HI_W];
	assign num_lo  = {sum_sel[END_W-FRAC_W-1:0], FRAC_W'(0)};
	// quotient would not fit END_W bits
	assign too_big = CNT_W'(num_hi) >= cnt_sel;

	// One restoring step
	assign trial  = {rem_q, num_q[END_W-1]};
	assign ge     = trial >= {1'b0, cnt_sel};
	assign diff   = trial - {1'b0, cnt_sel};
	assign quo_nx = {quo_q[END_W-2:0], ge};

	assign last_kind = kind_q == KIND_W'(KINDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stats_q <= '0;
			kind_q  <= '0;
			step_q  <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			ends_q  <= '0;
			empty_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						stats_q <= stats;
						kind_q  <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cnt_sel == '0 || too_big) begin
						// no events reads 0, oversize mean saturates
						ends_q[kind_q]  <= (cnt_sel == '0) ? '0 : '1;
						empty_q[kind_q] <= cnt_sel == '0;
						kind_q          <= kind_q + KIND_W'(1);
						state_q         <= last_kind ? ST_HOLD : ST_LOAD;
					end else begin
						empty_q[kind_q] <= 1'b0;
						rem_q           <= CNT_W'(num_hi);
						num_q           <= num_lo;
						step_q          <= '0;
						state_q         <= ST_STEP;
					end
				end
				ST_STEP: begin
					rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
					num_q  <= {num_q[END_W-2:0], 1'b0};
					quo_q  <= quo_nx;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(END_W - 1)) begin
						ends_q[kind_q] <= quo_nx;
						kind_q         <= kind_q + KIND_W'(1);
						state_q        <= last_kind ? ST_HOLD : ST_LOAD;
					end
				end
				ST_HOLD: begin
					if (taken) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign res_valid = state_q == ST_HOLD;

	assign res.pixel_is_red = stats_q.pixel_is_red;
	assign res.frame_done   = 1'b1;
	assign res.left_end     = ends_q[KIND_LEFT];
	assign res.right_end    = ends_q[KIND_RIGHT];
	assign res.top_end      = ends_q[KIND_TOP];
	assign res.bottom_end   = ends_q[KIND_BOTTOM];
	assign res.empty_mask   = empty_q;

	// Remainder stays below the divisor throughout the iteration
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> rem_q < cnt_sel)
		else $error("divider remainder out of range");

	// A new frame never arrives while a division is under way
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("divider started while busy");

endmodule

/* rtl/red_region_edge_locator.sv */
`timescale 1ns / 1ps

// Red region edge locator.
// Pixels enter in raster order on pixel_valid/pixel_ready, one BGR item per
// accepted cycle. Every pixel gives one result item on result_valid/
// result_ready holding its red bit; the last pixel of a frame also carries
// the four mean edge positions (12.8 fixed point) and the empty mask.
// Configuration is written on cfg_valid/cfg_ready (always ready) with
// cfg_index selecting the register; write only while the block is idle.
// Each result is registered in the output stage before it is shown.
// Throughput: one pixel per cycle within a frame, while no skid entry waits.
// On the last pixel the shared serial divider runs: a load step per kind,
// then the quotient steps for each kind with events, and pixel_ready stays
// low until the frame result has entered the output stage.
// Reset: thresholds 120/90/90, geometry 640 x 480, position and totals
// cleared. The row store is not cleared: row 0 never uses its contents.
// Back-pressure: an output register plus one skid entry; pixel_ready drops
// once the skid entry is occupied.
module red_region_edge_locator
	import rrel_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  pixel_item_t          pixel,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_item_t         result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	cfg_regs_t    cfg_q;
	logic         pix_accept;
	logic         is_red;
	logic         frame_end;
	frame_stats_t stats;
	logic         div_busy;
	logic         div_res_valid;
	result_item_t div_res;
	logic         push_pix, push_div, push, pop;
	result_item_t push_item;
	result_item_t out_q, skid_q;
	logic         out_valid_q, skid_valid_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_thr      <= RED_THR_RST;
			cfg_q.green_thr    <= GREEN_THR_RST;
			cfg_q.blue_thr     <= BLUE_THR_RST;
			cfg_q.frame_width  <= WIDTH_RST;
			cfg_q.frame_height <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED_THR:      cfg_q.red_thr      <= cfg_data[PIX_W-1:0];
				REG_GREEN_THR:    cfg_q.green_thr    <= cfg_data[PIX_W-1:0];
				REG_BLUE_THR:     cfg_q.blue_thr     <= cfg_data[PIX_W-1:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pixel path
	assign pixel_ready = !div_busy && !skid_valid_q;
	assign pix_accept  = pixel_valid && pixel_ready;

	rrel_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (pix_accept),
		.pix      (pixel),
		.is_red   (is_red),
		.frame_end(frame_end),
		.stats    (stats)
	);

	rrel_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pix_accept && frame_end),
		.stats    (stats),
		.taken    (push_div),
		.busy     (div_busy),
		.res_valid(div_res_valid),
		.res      (div_res)
	);

	// Items into the output stage: plain pixels, or the frame summary
	assign push_pix = pix_accept && !frame_end;
	assign push_div = div_res_valid && !skid_valid_q;
	assign push     = push_pix || push_div;
	assign pop      = out_valid_q && result_ready;

	always_comb begin
		push_item              = '0;
		push_item.pixel_is_red = is_red;
		if (push_div) begin
			push_item = div_res;
		end
	end

	// Output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_item;
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Skid entry only fills behind a waiting output item
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry occupied with output register empty");

	// The last pixel of a frame always hands over to the divider
	a_frame_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_accept && frame_end) |=> div_busy)
		else $error("frame end did not start the divider");

endmodule
